>>> sv/assert_macros.svh
// Assertion macros shared by the spin-bit RTT matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define SBRM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("sbrm assertion failed");
// Checks that a condition never holds at a rising clock edge outside reset.
`define SBRM_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sbrm forbidden condition seen");
`else
`define SBRM_ASSERT(lbl, clk, rst_n, prop)
`define SBRM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> sv/sbrm_pkg.sv
// Package with the types and constants of the spin-bit RTT matcher.
package sbrm_pkg;

	localparam int RING_DEPTH_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int TIME_W = 64;

	// One classified item on its way from the front end to the back end.
	typedef struct packed {
		logic              first_value;
		logic              flip;
		logic              rising;
		logic              dir;
		logic [TIME_W-1:0] stamp;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_CLEAR,
		ST_DONE
	} back_state_t;

endpackage

>>> sv/sbrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/sbrm_front.sv
// Front end: accepts packets and classifies them by their spin history.
module sbrm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       spin_bit,
	input  logic                       from_responder,
	input  logic [sbrm_pkg::TIME_W-1:0] packet_time,
	input  logic                       q_full,
	output logic                       push,
	output sbrm_pkg::cmd_t             push_cmd
);

	logic [1:0] known_q;
	logic [1:0] last_q;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_cmd.first_value = !known_q[from_responder];
		push_cmd.flip        = known_q[from_responder] && (spin_bit != last_q[from_responder]);
		push_cmd.rising      = !last_q[from_responder];
		push_cmd.dir         = from_responder;
		push_cmd.stamp       = packet_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= '0;
			last_q  <= '0;
		end else if (push) begin
			known_q[from_responder] <= 1'b1;
			last_q[from_responder]  <= spin_bit;
		end
	end

endmodule

>>> sv/sbrm_queue.sv
// Small FIFO of classified items between the front end and the back end.
`include "assert_macros.svh"
module sbrm_queue #(
	parameter int DEPTH = sbrm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbrm_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           pop_valid,
	input  logic           pop,
	output sbrm_pkg::cmd_t pop_cmd
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	sbrm_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SBRM_NEVER(a_q_overflow, clk, arst_n, push && full)
	`SBRM_NEVER(a_q_underflow, clk, arst_n, pop && !pop_valid)
	`SBRM_ASSERT(a_q_count_up, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + CW'(1)))

endmodule

>>> sv/sbrm_back.sv
// Back end: writes flips into the rings and searches them for matches.
`include "assert_macros.svh"
module sbrm_back #(
	parameter int RING_DEPTH = sbrm_pkg::RING_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  sbrm_pkg::cmd_t              cmd,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        first_value,
	output logic                        flip_seen,
	output logic                        flip_rising,
	output logic                        bidir_found,
	output logic [sbrm_pkg::TIME_W-1:0] bidir_time,
	output logic                        unidir_found,
	output logic [sbrm_pkg::TIME_W-1:0] unidir_time
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam int RW = sbrm_pkg::TIME_W + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

	sbrm_pkg::back_state_t state_q, state_d;
	sbrm_pkg::cmd_t        cur_q;

	logic [IW-1:0]         wslot_q [2];
	logic [RING_DEPTH-1:0] uni_q [2];
	logic [RING_DEPTH-1:0] bi_q [2];
	logic [IW-1:0]         prev_q;
	logic [CW-1:0]         cnt_q;
	logic                  chk_vld_s1;
	logic [IW-1:0]         chk_idx_s1;
	logic                  found_q;
	logic [sbrm_pkg::TIME_W-1:0] best_q;
	logic [IW-1:0]         pick_q;
	logic                  out_valid_q;

	logic [RW-1:0]         rdata [2];
	logic [1:0]            ram_we;
	logic [1:0]            ram_re;
	logic [IW-1:0]         ram_raddr [2];

	logic                  out_free;
	logic                  start;
	logic                  load_plain;
	logic                  load_flip;
	logic                  issue;
	logic [IW-1:0]         slot_new;
	logic [IW-1:0]         prev_new;
	logic                  odir;
	logic                  want;
	logic [sbrm_pkg::TIME_W-1:0] e_stamp;
	logic                  e_code;
	logic                  e_bi;
	logic                  last_chk;
	logic                  hit;
	logic                  clr;

	assign out_free = !out_valid_q || out_ready;
	assign slot_new = wslot_q[cmd.dir];
	assign prev_new = (slot_new == '0) ? LAST_IDX : slot_new - 1'b1;
	assign odir     = !cur_q.dir;
	// A responder flip matches an equal code, an initiator flip the inverse one.
	assign want     = cur_q.dir ? cur_q.rising : !cur_q.rising;
	assign e_stamp  = rdata[odir][sbrm_pkg::TIME_W-1:0];
	assign e_code   = rdata[odir][RW-1];
	assign e_bi     = bi_q[odir][chk_idx_s1];
	assign last_chk = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);
	assign hit = (state_q == sbrm_pkg::ST_FIND) && chk_vld_s1 && e_bi && (e_code == want)
		&& (!found_q || (e_stamp < best_q));
	assign clr = (state_q == sbrm_pkg::ST_CLEAR) && chk_vld_s1 && e_bi
		&& ((e_stamp < best_q) || (chk_idx_s1 == pick_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sbrm_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.flip) begin
					state_d = sbrm_pkg::ST_FIND;
				end
			end
			sbrm_pkg::ST_FIND: begin
				if (last_chk) begin
					state_d = (found_q || hit) ? sbrm_pkg::ST_CLEAR : sbrm_pkg::ST_DONE;
				end
			end
			sbrm_pkg::ST_CLEAR: begin
				if (last_chk) begin
					state_d = sbrm_pkg::ST_DONE;
				end
			end
			sbrm_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sbrm_pkg::ST_IDLE;
				end
			end
			default: state_d = sbrm_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		pop        = 1'b0;
		start      = 1'b0;
		load_plain = 1'b0;
		load_flip  = 1'b0;
		issue      = 1'b0;
		case (state_q)
			sbrm_pkg::ST_IDLE: begin
				if (cmd_valid && cmd.flip) begin
					pop   = 1'b1;
					start = 1'b1;
				end else if (cmd_valid && out_free) begin
					pop        = 1'b1;
					load_plain = 1'b1;
				end
			end
			sbrm_pkg::ST_FIND, sbrm_pkg::ST_CLEAR: begin
				issue = (cnt_q < CW'(RING_DEPTH));
			end
			sbrm_pkg::ST_DONE: begin
				load_flip = out_free;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int x = 0; x < 2; x++) begin
			ram_we[x]    = start && (cmd.dir == 1'(x));
			ram_re[x]    = ram_we[x] || (issue && (cur_q.dir != 1'(x)));
			ram_raddr[x] = start ? prev_new : cnt_q[IW-1:0];
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_ring
		sbrm_ram #(
			.WIDTH(RW),
			.DEPTH(RING_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[g]),
			.waddr(wslot_q[g]),
			.wdata({cmd.rising, cmd.stamp}),
			.re   (ram_re[g]),
			.raddr(ram_raddr[g]),
			.rdata(rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbrm_pkg::ST_IDLE;
			wslot_q     <= '{default: '0};
			uni_q       <= '{default: '0};
			bi_q        <= '{default: '0};
			cnt_q       <= '0;
			chk_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= issue;
			if (start) begin
				uni_q[cmd.dir][slot_new] <= 1'b1;
				bi_q[cmd.dir][slot_new]  <= 1'b1;
				wslot_q[cmd.dir] <= (slot_new == LAST_IDX) ? '0 : slot_new + 1'b1;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end else if ((state_q == sbrm_pkg::ST_FIND) && last_chk) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (clr) begin
				bi_q[odir][chk_idx_s1] <= 1'b0;
			end
			if (load_flip) begin
				uni_q[cur_q.dir][prev_q] <= 1'b0;
			end
			if (load_plain || load_flip) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= cnt_q[IW-1:0];
		if (start) begin
			cur_q  <= cmd;
			prev_q <= prev_new;
		end
		if (hit) begin
			best_q <= e_stamp;
			pick_q <= chk_idx_s1;
		end
		if (load_plain) begin
			first_value  <= cmd.first_value;
			flip_seen    <= 1'b0;
			flip_rising  <= 1'b0;
			bidir_found  <= 1'b0;
			bidir_time   <= '0;
			unidir_found <= 1'b0;
			unidir_time  <= '0;
		end else if (load_flip) begin
			first_value  <= 1'b0;
			flip_seen    <= 1'b1;
			flip_rising  <= cur_q.rising;
			bidir_found  <= found_q;
			bidir_time   <= found_q ? best_q : '0;
			unidir_found <= uni_q[cur_q.dir][prev_q];
			unidir_time  <= uni_q[cur_q.dir][prev_q] ?
				rdata[cur_q.dir][sbrm_pkg::TIME_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;

	`SBRM_ASSERT(a_out_free, clk, arst_n, (load_plain || load_flip) |-> out_free)
	`SBRM_ASSERT(a_clear_found, clk, arst_n, (state_q == sbrm_pkg::ST_CLEAR) |-> found_q)
	`SBRM_ASSERT(a_start_marks, clk, arst_n,
		start |=> (uni_q[cur_q.dir][$past(slot_new)] && bi_q[cur_q.dir][$past(slot_new)]))

endmodule

>>> sv/spin_bit_rtt_matcher_unit.sv
// Top level of the spin-bit RTT matcher: front end, item queue and back end.
// The block watches the spin bit of each packet of a connection, one item per
// packet, and returns exactly one result item for each. The front end keeps the
// last spin value of each direction and classifies every item at once as the
// first value of its direction, a repeat or a flip, so it takes one item per
// cycle for as long as the queue has room. The back end works the items in
// order. A flip is written into its direction's ring, after which the other
// direction's ring is read from its RAM one entry per cycle to find the
// earliest fitting flip that is still pending, and, when one is found, read a
// second time to retire that entry and every older one; the previous flip of
// the own ring gives the unidirectional result. A flip therefore occupies the
// back end for one walk of the ring when nothing matches and for two when a
// match is found, and these walks set the sustained rate. The result waits in
// an output register. A flip is taken and searched while the previous result
// is still unclaimed, and only its own result waits for the register to free
// up; a first value or a repeat stays in the queue until the register is
// empty or is being read in that cycle.
module spin_bit_rtt_matcher_unit #(
	parameter int RING_DEPTH  = sbrm_pkg::RING_DEPTH_DEF,
	parameter int QUEUE_DEPTH = sbrm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Packet items.
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        spin_bit,
	input  logic                        from_responder,
	input  logic [sbrm_pkg::TIME_W-1:0] packet_time,
	// Result items.
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        first_value,
	output logic                        flip_seen,
	output logic                        flip_rising,
	output logic                        bidir_found,
	output logic [sbrm_pkg::TIME_W-1:0] bidir_time,
	output logic                        unidir_found,
	output logic [sbrm_pkg::TIME_W-1:0] unidir_time
);

	sbrm_pkg::cmd_t push_cmd;
	sbrm_pkg::cmd_t pop_cmd;
	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           pop;

	// Classification of each packet against the stored spin history.
	sbrm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.spin_bit      (spin_bit),
		.from_responder(from_responder),
		.packet_time   (packet_time),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// The queue lets the front end keep accepting while a flip is searched.
	sbrm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (pop),
		.pop_cmd  (pop_cmd)
	);

	// Ring bookkeeping, matching and the output register.
	sbrm_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (pop_cmd),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.first_value (first_value),
		.flip_seen   (flip_seen),
		.flip_rising (flip_rising),
		.bidir_found (bidir_found),
		.bidir_time  (bidir_time),
		.unidir_found(unidir_found),
		.unidir_time (unidir_time)
	);

endmodule

>>> sim/testbench.sv
// Self-checking testbench of the spin-bit RTT matcher unit: directed and random packet items.
`timescale 1ns / 100ps

module testbench;

	localparam int RING = sbrm_pkg::RING_DEPTH_DEF;
	localparam int TW = sbrm_pkg::TIME_W;
	// Watchdog limit, set well above the length of the slowest correct run.
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PER_PHASE = 600;
	// Settling time, longer than a matched flip keeps the back end busy.
	localparam int SETTLE_CYCLES = 4 * RING + 16;
	localparam int HOLD_AFTER_RESULTS = 400;
	localparam int HOLD_CYCLES = 250;

	typedef logic [TW-1:0] stamp_t;

	typedef struct packed {
		logic   first_value;
		logic   flip_seen;
		logic   flip_rising;
		logic   bidir_found;
		stamp_t bidir_time;
		logic   unidir_found;
		stamp_t unidir_time;
	} rtt_result_t;

	// Tracks the spin state and flip rings of both directions and keeps the results
	// that the block still owes, oldest first.
	class rtt_scoreboard;
		bit          spin_known [2];
		bit          last_spin [2];
		int unsigned next_slot [2];
		stamp_t      ring_stamp [2][RING];
		bit          ring_rising [2][RING];
		bit          uni_pending [2][RING];
		bit          bi_pending [2][RING];
		int unsigned flips [2];
		rtt_result_t awaited [$];
		int unsigned errors;

		function new();
			for (int d = 0; d < 2; d++) begin
				spin_known[d] = 0;
				last_spin[d] = 0;
				next_slot[d] = 0;
				flips[d] = 0;
				for (int i = 0; i < RING; i++) begin
					ring_stamp[d][i] = '0;
					ring_rising[d][i] = 0;
					uni_pending[d][i] = 0;
					bi_pending[d][i] = 0;
				end
			end
			errors = 0;
		endfunction

		function void note_packet(bit spin, bit dir, stamp_t stamp);
			rtt_result_t r;
			int          pick;
			int unsigned slot;
			int unsigned prev;
			bit          odir;
			bit          rising;
			bit          want_code;
			r = '0;
			odir = ~dir;
			if (!spin_known[dir]) begin
				// The first packet of a direction only records its spin value.
				spin_known[dir] = 1;
				last_spin[dir] = spin;
				r.first_value = 1'b1;
			end else if (spin != last_spin[dir]) begin
				rising = (last_spin[dir] == 1'b0);
				last_spin[dir] = spin;
				slot = next_slot[dir];
				ring_stamp[dir][slot] = stamp;
				ring_rising[dir][slot] = rising;
				uni_pending[dir][slot] = 1;
				bi_pending[dir][slot] = 1;
				next_slot[dir] = (slot + 1) % RING;
				flips[dir]++;
				r.flip_seen = 1'b1;
				r.flip_rising = rising;
				// A responder flip pairs with an equal code, an initiator flip with the inverse.
				want_code = dir ? rising : ~rising;
				pick = -1;
				for (int i = 0; i < RING; i++) begin
					if (bi_pending[odir][i] && ring_rising[odir][i] == want_code &&
							(pick < 0 || ring_stamp[odir][i] < ring_stamp[odir][pick]))
						pick = i;
				end
				if (pick >= 0) begin
					r.bidir_found = 1'b1;
					r.bidir_time = ring_stamp[odir][pick];
					// Everything strictly older is retired too, whatever its code.
					for (int i = 0; i < RING; i++) begin
						if (bi_pending[odir][i] && ring_stamp[odir][i] < r.bidir_time)
							bi_pending[odir][i] = 0;
					end
					bi_pending[odir][pick] = 0;
				end
				prev = (next_slot[dir] + RING - 2) % RING;
				if (uni_pending[dir][prev]) begin
					uni_pending[dir][prev] = 0;
					r.unidir_found = 1'b1;
					r.unidir_time = ring_stamp[dir][prev];
				end
			end
			awaited.push_back(r);
		endfunction

		function void check_field(string name, stamp_t want, stamp_t got);
			if (want !== got) begin
				$display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rtt_result_t got);
			rtt_result_t want;
			if (awaited.size() == 0) begin
				$display("%0t result item with nothing awaited: %h", $time, got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			check_field("first_value", want.first_value, got.first_value);
			check_field("flip_seen", want.flip_seen, got.flip_seen);
			check_field("flip_rising", want.flip_rising, got.flip_rising);
			check_field("bidir_found", want.bidir_found, got.bidir_found);
			check_field("bidir_time", want.bidir_time, got.bidir_time);
			check_field("unidir_found", want.unidir_found, got.unidir_found);
			check_field("unidir_time", want.unidir_time, got.unidir_time);
		endfunction
	endclass

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	logic   spin_bit = 1'b0;
	logic   from_responder = 1'b0;
	stamp_t packet_time = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	logic   first_value;
	logic   flip_seen;
	logic   flip_rising;
	logic   bidir_found;
	stamp_t bidir_time;
	logic   unidir_found;
	stamp_t unidir_time;

	rtt_scoreboard sb;
	int unsigned   cycles = 0;
	int unsigned   results_seen = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;
	bit            drv_spin [2] = '{1'b0, 1'b0};
	stamp_t        drv_clock = '0;

	spin_bit_rtt_matcher_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.spin_bit       (spin_bit),
		.from_responder (from_responder),
		.packet_time    (packet_time),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.first_value    (first_value),
		.flip_seen      (flip_seen),
		.flip_rising    (flip_rising),
		.bidir_found    (bidir_found),
		.bidir_time     (bidir_time),
		.unidir_found   (unidir_found),
		.unidir_time    (unidir_time)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// Receiver side. Every accepted result item is checked against the oldest awaited
	// one. Once, after a few hundred results, the receiver holds off for a long
	// stretch so that the queue fills and the block has to stall its input.
	initial begin
		int unsigned hold_left;
		rtt_result_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {first_value, flip_seen, flip_rising, bidir_found, bidir_time,
					unidir_found, unidir_time};
				sb.check_result(got);
				results_seen++;
				if (results_seen == HOLD_AFTER_RESULTS)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one packet item, with random idle cycles in front of it, and returns in
	// the time step of the clock edge that accepted it.
	task automatic send_packet(input bit spin, input bit dir, input stamp_t stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		spin_bit <= spin;
		from_responder <= dir;
		packet_time <= stamp;
		do @(posedge clk); while (!in_ready);
		sb.note_packet(spin, dir, stamp);
		drv_spin[dir] = spin;
	endtask

	// Mostly a well-formed packet stream: monotonic time, often equal stamps, and a
	// flip in most items. The rest are repeats and stray timestamps anywhere in the
	// 64-bit range, some of which restart the time base.
	task automatic send_random_packet();
		bit     dir;
		bit     spin;
		int     sel;
		stamp_t stamp;
		dir = 1'($urandom_range(1));
		if ($urandom_range(99) < 75)
			spin = ~drv_spin[dir];
		else
			spin = 1'($urandom_range(1));
		sel = $urandom_range(99);
		if (sel < 85) begin
			if ($urandom_range(3) != 0)
				drv_clock = drv_clock + $urandom_range(1, 500);
			stamp = drv_clock;
		end else if (sel < 93) begin
			stamp = {$urandom, $urandom};
		end else begin
			drv_clock = {$urandom, $urandom};
			stamp = drv_clock;
		end
		send_packet(spin, dir, stamp);
	endtask

	// The sender stops until every awaited result item has come back.
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// First values of both directions, each followed by a repeat.
		send_packet(1'b0, 1'b0, 64'd0);
		send_packet(1'b0, 1'b0, 64'd1);
		send_packet(1'b1, 1'b1, 64'd2);
		send_packet(1'b1, 1'b1, 64'd3);
		// Rising and falling flips in both directions, on equal timestamps.
		send_packet(1'b1, 1'b0, 64'd10);
		send_packet(1'b0, 1'b1, 64'd10);
		send_packet(1'b0, 1'b0, 64'd20);
		send_packet(1'b1, 1'b1, 64'd20);
		// A run of initiator flips with equal stamps overwrites its ring.
		send_packet(1'b1, 1'b0, 64'd30);
		send_packet(1'b0, 1'b0, 64'd30);
		send_packet(1'b1, 1'b0, 64'd30);
		send_packet(1'b0, 1'b0, 64'd30);
		send_packet(1'b1, 1'b0, 64'd31);
		// Responder flips that search the tied initiator entries.
		send_packet(1'b0, 1'b1, 64'd40);
		send_packet(1'b1, 1'b1, 64'd40);
		send_packet(1'b0, 1'b1, 64'd41);
		// Timestamp extremes and a sequence that goes backward in time.
		send_packet(1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_packet(1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_packet(1'b1, 1'b0, 64'd0);
		send_packet(1'b0, 1'b1, 64'd0);
		send_packet(1'b1, 1'b1, 64'h8000_0000_0000_0000);
		send_packet(1'b0, 1'b0, 64'h5555_5555_5555_5555);
		send_packet(1'b1, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
		wait_results_done();

		// Random part in three phases of idling.
		drv_clock = 64'd1000;
		send_idle_pct = 6;
		recv_idle_pct = 58;
		repeat (RANDOM_PER_PHASE) send_random_packet();
		wait_results_done();

		send_idle_pct = 58;
		recv_idle_pct = 6;
		repeat (RANDOM_PER_PHASE) send_random_packet();
		wait_results_done();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (RANDOM_PER_PHASE) send_random_packet();
		wait_results_done();

		// Leave room for any stray result item before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> spin_bit_rtt_matcher_unit.f
+incdir+sv
sv/sbrm_pkg.sv
sv/sbrm_ram.sv
sv/sbrm_front.sv
sv/sbrm_queue.sv
sv/sbrm_back.sv
sv/spin_bit_rtt_matcher_unit.sv
sim/testbench.sv
